// ===== rtl/core/sass_pkg.sv =====
// ----------------------------------------------------------------------------
// sass_pkg
// Shared types, codes and defaults of the slide advance and scan sequencer.
// ----------------------------------------------------------------------------
package sass_pkg;

    localparam int TIMER_BITS_DEF = 16;
    localparam int COUNT_BITS_DEF = 8;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SLIDES_TO_SCAN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANGE_DELAY_MS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANGE_PULSE_MS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_DELAY_MS   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_IR_ENABLE       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_CABLE_ENABLE    = 3'd5;

    typedef enum logic [3:0] {
        REQ_TICK      = 4'd0,
        REQ_NEXT      = 4'd1,
        REQ_LAST      = 4'd2,
        REQ_START     = 4'd3,
        REQ_STOP      = 4'd4,
        REQ_SCAN      = 4'd5,
        REQ_CLEAR     = 4'd6,
        REQ_ERROR     = 4'd7,
        REQ_SET_COUNT = 4'd8
    } t_req;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_ERROR = 3'd1,
        MODE_NEXT  = 3'd2,
        MODE_LAST  = 3'd3,
        MODE_SCAN  = 3'd4
    } t_mode;

    typedef enum logic [2:0] {
        FOOT_NONE = 3'd0,
        FOOT_AUTO = 3'd1,
        FOOT_NEXT = 3'd2,
        FOOT_LAST = 3'd3,
        FOOT_SCAN = 3'd4
    } t_footer;

    typedef struct packed {
        logic [7:0]  slides_to_scan;
        logic [15:0] change_delay_ms;
        logic [15:0] change_pulse_ms;
        logic [15:0] scan_delay_ms;
        logic        ir_enable;
        logic        cable_enable;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        slides_to_scan:  8'd50,
        change_delay_ms: 16'd2000,
        change_pulse_ms: 16'd200,
        scan_delay_ms:   16'd1000,
        ir_enable:       1'b1,
        cable_enable:    1'b0
    };

    typedef struct packed {
        t_mode   mode;
        logic    auto_active;
        logic    next_drive;
        logic    last_drive;
        logic    ir_trigger;
        logic    cable_trigger;
        t_footer footer_mode;
        logic    count_changed;
    } t_flags;

endpackage

// ===== rtl/core/sass_core.sv =====
// ----------------------------------------------------------------------------
// sass_core
// Sequencer state, millisecond timers and the per-item next-state logic.
// ----------------------------------------------------------------------------
module sass_core
    import sass_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_take,
    input  logic [3:0]            i_req_type,
    input  logic [7:0]            i_slide_value,
    input  t_cfg                  i_cfg,
    output t_flags                o_flags,
    output logic [COUNT_BITS-1:0] o_count
);

    localparam int TW = (TIMER_BITS > 16) ? TIMER_BITS : 16;
    localparam int CW = (COUNT_BITS > 8) ? COUNT_BITS : 8;
    localparam logic [TW-1:0] TMAX_W = TW'({TIMER_BITS{1'b1}});
    localparam logic [CW-1:0] CMAX_W = CW'({COUNT_BITS{1'b1}});

    function automatic logic [TIMER_BITS-1:0] sat_t(input logic [15:0] v);
        logic [TW-1:0] w;
        w = TW'(v);
        return (w > TMAX_W) ? {TIMER_BITS{1'b1}} : TIMER_BITS'(w);
    endfunction

    function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] v);
        return (v == {TIMER_BITS{1'b1}}) ? v : v + 1'b1;
    endfunction

    t_mode                 r_fsm,      n_fsm;
    logic [COUNT_BITS-1:0] r_cnt,      n_cnt;
    logic                  r_auto,     n_auto;
    logic [TIMER_BITS-1:0] r_dly_el,   n_dly_el;
    logic [TIMER_BITS-1:0] r_dly_tgt,  n_dly_tgt;
    logic                  r_dly_run,  n_dly_run;
    logic [TIMER_BITS-1:0] r_pls_el,   n_pls_el;
    logic                  r_pls_run,  n_pls_run;
    logic                  r_next_ln,  n_next_ln;
    logic                  r_last_ln,  n_last_ln;
    t_footer               r_footer,   n_footer;

    logic [COUNT_BITS-1:0] lim;
    logic                  ir_stb, cable_stb, cnt_wr;

    assign lim = (CW'(i_cfg.slides_to_scan) > CMAX_W) ? {COUNT_BITS{1'b1}}
                                                     : COUNT_BITS'(i_cfg.slides_to_scan);

    always_comb begin : step
        logic go_next, go_last, go_scan, go_err, go_idle;
        go_next   = 1'b0;
        go_last   = 1'b0;
        go_scan   = 1'b0;
        go_err    = 1'b0;
        go_idle   = 1'b0;
        ir_stb    = 1'b0;
        cable_stb = 1'b0;
        cnt_wr    = 1'b0;
        n_fsm     = r_fsm;
        n_cnt     = r_cnt;
        n_auto    = r_auto;
        n_dly_el  = r_dly_el;
        n_dly_tgt = r_dly_tgt;
        n_dly_run = r_dly_run;
        n_pls_el  = r_pls_el;
        n_pls_run = r_pls_run;
        n_next_ln = r_next_ln;
        n_last_ln = r_last_ln;
        n_footer  = r_footer;

        // Decide which entry action the request calls for; set-count writes the count and ticks advance the timers
        if (i_req_type == REQ_SET_COUNT) begin
            n_cnt  = COUNT_BITS'(CW'(i_slide_value));
            cnt_wr = 1'b1;
        end else if (i_req_type == REQ_TICK) begin
            if (r_pls_run) begin
                n_pls_el = sat_inc(r_pls_el);
                if (n_pls_el >= sat_t(i_cfg.change_pulse_ms)) begin
                    n_pls_run = 1'b0;
                    n_next_ln = 1'b0;
                    n_last_ln = 1'b0;
                end
            end
            if (r_dly_run) begin
                n_dly_el = sat_inc(r_dly_el);
                if (n_dly_el >= r_dly_tgt) begin
                    n_dly_run = 1'b0;
                    case (r_fsm)
                        MODE_NEXT: begin
                            if (r_auto) go_scan = 1'b1;
                            else        go_idle = 1'b1;
                        end
                        MODE_LAST: go_idle = 1'b1;
                        MODE_SCAN: begin
                            if ((r_cnt < lim) && r_auto) go_next = 1'b1;
                            else                         go_idle = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
        end else if (r_fsm == MODE_ERROR) begin
            // latched until reset
        end else if (i_req_type == REQ_ERROR) begin
            go_err = 1'b1;
        end else if (i_req_type > REQ_SET_COUNT) begin
            go_idle = 1'b1;
        end else if (r_fsm == MODE_IDLE) begin
            case (i_req_type)
                REQ_NEXT: begin
                    n_auto  = 1'b0;
                    go_next = 1'b1;
                end
                REQ_LAST: begin
                    n_auto  = 1'b0;
                    go_last = 1'b1;
                end
                REQ_START: begin
                    n_auto   = 1'b1;
                    n_footer = FOOT_AUTO;
                    go_next  = 1'b1;
                end
                REQ_SCAN: begin
                    n_auto  = 1'b0;
                    go_scan = 1'b1;
                end
                REQ_CLEAR: begin
                    n_cnt  = '0;
                    cnt_wr = 1'b1;
                end
                default: ;
            endcase
        end else if (i_req_type == REQ_STOP || i_req_type == REQ_CLEAR) begin
            go_idle = 1'b1;
        end

        // Apply the entry actions
        if (go_next) begin
            if (!n_auto) n_footer = FOOT_NEXT;
            if (n_cnt < lim) begin
                n_cnt     = n_cnt + 1'b1;
                cnt_wr    = 1'b1;
                n_fsm     = MODE_NEXT;
                n_next_ln = 1'b1;
                n_dly_tgt = sat_t(i_cfg.change_delay_ms);
                n_dly_el  = '0;
                n_dly_run = 1'b1;
                n_pls_el  = '0;
                n_pls_run = 1'b1;
            end else begin
                go_idle = 1'b1;
            end
        end
        if (go_last) begin
            if (!n_auto) n_footer = FOOT_LAST;
            if (n_cnt != '0) begin
                n_cnt     = n_cnt - 1'b1;
                cnt_wr    = 1'b1;
                n_fsm     = MODE_LAST;
                n_last_ln = 1'b1;
                n_dly_tgt = sat_t(i_cfg.change_delay_ms);
                n_dly_el  = '0;
                n_dly_run = 1'b1;
                n_pls_el  = '0;
                n_pls_run = 1'b1;
            end else begin
                go_idle = 1'b1;
            end
        end
        if (go_scan) begin
            if (!n_auto) n_footer = FOOT_SCAN;
            n_fsm     = MODE_SCAN;
            ir_stb    = i_cfg.ir_enable;
            cable_stb = i_cfg.cable_enable;
            n_dly_tgt = sat_t(i_cfg.scan_delay_ms);
            n_dly_el  = '0;
            n_dly_run = 1'b1;
        end
        if (go_err) begin
            n_fsm     = MODE_ERROR;
            n_next_ln = 1'b0;
            n_last_ln = 1'b0;
            n_dly_run = 1'b0;
            n_pls_run = 1'b0;
        end
        if (go_idle) begin
            n_fsm     = MODE_IDLE;
            n_footer  = FOOT_NONE;
            n_next_ln = 1'b0;
            n_last_ln = 1'b0;
            n_dly_run = 1'b0;
            n_pls_run = 1'b0;
            n_auto    = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm     <= MODE_IDLE;
            r_cnt     <= '0;
            r_auto    <= 1'b0;
            r_dly_el  <= '0;
            r_dly_tgt <= '0;
            r_dly_run <= 1'b0;
            r_pls_el  <= '0;
            r_pls_run <= 1'b0;
            r_next_ln <= 1'b0;
            r_last_ln <= 1'b0;
            r_footer  <= FOOT_NONE;
        end else if (i_take) begin
            r_fsm     <= n_fsm;
            r_cnt     <= n_cnt;
            r_auto    <= n_auto;
            r_dly_el  <= n_dly_el;
            r_dly_tgt <= n_dly_tgt;
            r_dly_run <= n_dly_run;
            r_pls_el  <= n_pls_el;
            r_pls_run <= n_pls_run;
            r_next_ln <= n_next_ln;
            r_last_ln <= n_last_ln;
            r_footer  <= n_footer;
        end
    end

    assign o_flags = '{
        mode:          n_fsm,
        auto_active:   n_auto,
        next_drive:    n_next_ln,
        last_drive:    n_last_ln,
        ir_trigger:    ir_stb,
        cable_trigger: cable_stb,
        footer_mode:   n_footer,
        count_changed: cnt_wr
    };
    assign o_count = n_cnt;

endmodule

// ===== rtl/core/slide_advance_scan_sequencer.sv =====
// ----------------------------------------------------------------------------
// slide_advance_scan_sequencer
// Slide projector advance and camera scan sequencer with ms timers.
// ----------------------------------------------------------------------------
// Each accepted item (a millisecond tick or a command) produces exactly one
// result item in the next cycle. The sequencer state is updated in
// the same cycle the item is taken, and the result sits in a single output
// register; a new item is taken whenever that register is empty or is being
// emptied in the same cycle, so the block sustains one item per clock and
// only stalls while the output side holds ready low. Tick items advance the
// change pulse and delay timers by one count; all time values are therefore
// in ticks. Configuration writes land in the register set at once; write
// them only while no result is pending.
// ----------------------------------------------------------------------------
module slide_advance_scan_sequencer
    import sass_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // request items
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [3:0]            i_req_type,
    input  logic [7:0]            i_slide_value,
    // result items
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [2:0]            o_mode,
    output logic [COUNT_BITS-1:0] o_slide_count,
    output logic                  o_auto_active,
    output logic                  o_next_drive,
    output logic                  o_last_drive,
    output logic                  o_ir_trigger,
    output logic                  o_cable_trigger,
    output logic [2:0]            o_footer_mode,
    output logic                  o_count_changed
);

    t_cfg                  r_cfg;
    logic                  take;
    t_flags                n_flags;
    logic [COUNT_BITS-1:0] n_count;
    logic                  r_out_valid;
    t_flags                r_flags;
    logic [COUNT_BITS-1:0] r_count;

    // Register set: write at once, unknown indexes drop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SLIDES_TO_SCAN:  r_cfg.slides_to_scan  <= i_cfg_data[7:0];
                CFG_CHANGE_DELAY_MS: r_cfg.change_delay_ms <= i_cfg_data[15:0];
                CFG_CHANGE_PULSE_MS: r_cfg.change_pulse_ms <= i_cfg_data[15:0];
                CFG_SCAN_DELAY_MS:   r_cfg.scan_delay_ms   <= i_cfg_data[15:0];
                CFG_IR_ENABLE:       r_cfg.ir_enable       <= i_cfg_data[0];
                CFG_CABLE_ENABLE:    r_cfg.cable_enable    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Take an item whenever the result register is free or drains this cycle
    assign o_in_ready = i_rst_n && (!r_out_valid || i_out_ready);
    assign take       = i_in_valid && o_in_ready;

    sass_core #(
        .TIMER_BITS (TIMER_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (take),
        .i_req_type    (i_req_type),
        .i_slide_value (i_slide_value),
        .i_cfg         (r_cfg),
        .o_flags       (n_flags),
        .o_count       (n_count)
    );

    // Result register: load on take, drop the valid once the item leaves
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_flags <= n_flags;
            r_count <= n_count;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_mode          = r_flags.mode;
    assign o_slide_count   = r_count;
    assign o_auto_active   = r_flags.auto_active;
    assign o_next_drive    = r_flags.next_drive;
    assign o_last_drive    = r_flags.last_drive;
    assign o_ir_trigger    = r_flags.ir_trigger;
    assign o_cable_trigger = r_flags.cable_trigger;
    assign o_footer_mode   = r_flags.footer_mode;
    assign o_count_changed = r_flags.count_changed;

endmodule

// ===== rtl/core/sass_checker.sv =====
// ----------------------------------------------------------------------------
// sass_checker
// Port-level checks of the sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module sass_checker
    import sass_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic [2:0]            o_mode,
    input logic [COUNT_BITS-1:0] o_slide_count,
    input logic                  o_auto_active,
    input logic                  o_next_drive,
    input logic                  o_last_drive,
    input logic                  o_ir_trigger,
    input logic                  o_cable_trigger
);

    // an accepted item shows a result on the next cycle
    a_take_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && i_in_valid && o_in_ready |=> o_out_valid)
        else $error("accepted item produced no result");

    // hold a stalled result
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n && o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_mode) && $stable(o_slide_count))
        else $error("stalled result changed");

    // idle and error keep both drive lines low
    a_lines_low: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_mode == MODE_IDLE || o_mode == MODE_ERROR) |->
            !o_next_drive && !o_last_drive)
        else $error("drive line high outside a move");

    // camera triggers fire only on scan entry
    a_trigger_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_ir_trigger || o_cable_trigger) |-> o_mode == MODE_SCAN)
        else $error("trigger outside scan");

    // idle clears auto
    a_idle_no_auto: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_mode == MODE_IDLE |-> !o_auto_active)
        else $error("auto flag set while idle");

endmodule

bind slide_advance_scan_sequencer sass_checker #(.COUNT_BITS(COUNT_BITS)) u_sass_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_ready      (o_in_ready),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_mode          (o_mode),
    .o_slide_count   (o_slide_count),
    .o_auto_active   (o_auto_active),
    .o_next_drive    (o_next_drive),
    .o_last_drive    (o_last_drive),
    .o_ir_trigger    (o_ir_trigger),
    .o_cable_trigger (o_cable_trigger)
);
